>>> src/e2h_pkg.sv
// ----------------------------------------------------------------------------
// e2h_pkg
// Shared types, constants and helper functions for the equatorial to
// horizontal coordinate converter.
// ----------------------------------------------------------------------------
package e2h_pkg;

   // default angle word width and CORDIC depth
   localparam int ANGLE_BITS_DEFAULT        = 32;
   localparam int CORDIC_ITERATIONS_DEFAULT = 32;

   // CORDIC vector width (signed Q30 with headroom for gain and overshoot)
   localparam int VW = 34;

   // front pipeline depth and queue depth
   localparam int FRONT_STAGES = 10;
   localparam int QUEUE_DEPTH  = 4;

   localparam int CSR_INDEX_BITS = 1;

   // time base constants
   localparam logic [63:0] J2000_UNIX      = 64'd946728000;
   localparam logic [31:0] SEC_PER_CENTURY = 32'd3155760000;
   localparam logic [38:0] POLY_SPAN       = 39'd1 << 38;

   // reciprocal of seconds per century, centuries per second * 2^64
   localparam logic [32:0] T_RECIP = 33'((128'd1 << 64) / 128'd3155760000);

   // sidereal time polynomial coefficients
   localparam logic [63:0] GMST_C0 =
      64'((128'd28046061837 << 64) / 128'd36000000000);
   localparam logic [47:0] GMST_RATE =
      48'((128'd36098564736629 << 64) / 128'd3110400000000000000);
   localparam logic [28:0] GMST_QUAD =
      29'(((128'd387933 << 64) / 128'd360000000000) >> 16);
   localparam logic [22:0] GMST_CUBE =
      23'(((128'd1 << 64) / 128'd13935600000) >> 8);

   localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;
   localparam logic signed [VW-1:0] INV_GAIN_Q30 = VW'(652032874);

   // configuration register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LONGITUDE,
      CSR_LATITUDE
   } csr_index_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic signed [63:0] unix_seconds;
      logic        [31:0] ra_turns;
      logic signed [31:0] declination;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] altitude;
      logic        [31:0] azimuth;
   } rsp_payload_type;

   // Q30 product, floored
   function automatic logic signed [VW-1:0] mulq(input logic signed [VW-1:0] a,
                                                 input logic signed [VW-1:0] b);
      logic signed [2*VW-1:0] p;
      p = a * b;
      return p[VW+29:30];
   endfunction

   // arctangent of 2^-i as a fraction of a turn, rounded to bits
   function automatic logic [63:0] atan_entry(input int unsigned i,
                                              input int unsigned bits);
      logic [63:0]  rad;
      logic [63:0]  term;
      logic [127:0] prod;
      logic [64:0]  t64;
      int unsigned  e;
      int unsigned  k;
      rad = '0;
      for (k = 0; k < 32; k++) begin
         e = i * (2 * k + 1);
         if (e <= 62) begin
            term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
            if (k[0]) begin
               rad = rad - term;
            end else begin
               rad = rad + term;
            end
         end
      end
      prod = {64'd0, rad} * {64'd0, INV_TWO_PI_Q64};
      t64  = {1'b0, prod[125:62]};
      t64  = t64 + (65'd1 << (63 - bits));
      if (i == 0) begin
         return 64'd1 << (bits - 3);
      end
      return 64'(t64 >> (64 - bits));
   endfunction

endpackage

>>> src/e2h_front.sv
// ----------------------------------------------------------------------------
// e2h_front
// Accepts requests and works out the hour angle: sidereal time polynomial,
// longitude and right ascension, over a ten stage pipeline.
// ----------------------------------------------------------------------------
module e2h_front #(
   parameter int ANGLE_BITS = e2h_pkg::ANGLE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  e2h_pkg::req_payload_type      req_payload,
   input  logic signed [31:0]            longitude,
   input  e2h_pkg::q_status_type         q_status,
   output logic                          q_push,
   output logic [ANGLE_BITS+31:0]        q_push_data
);

   localparam int LAST = e2h_pkg::FRONT_STAGES - 1;
   // side slot that picks up the linear sidereal term
   localparam int LIN_STAGE = 3;

   typedef struct packed {
      logic [63:0] lin;
      logic [31:0] ra;
      logic [31:0] dec;
      logic        neg;
   } side_type;

   logic                     adv;
   logic [LAST:0]            vld_ff;
   side_type                 side_ff [e2h_pkg::FRONT_STAGES];
   side_type                 side_in;

   logic [64:0]              d_in;
   logic [64:0]              d_ff;
   logic [64:0]              absd_in;
   logic [63:0]              sw_ff;
   logic [38:0]              mag_ff;
   logic [38:0]              mag_in;
   logic [52:0]              pl_ff;
   logic [51:0]              ph_ff;
   logic [63:0]              p0_ff;
   logic [47:0]              p1_ff;
   logic [31:0]              p2_ff;
   logic [38:0]              magc_ff;
   logic [31:0]              q_ff;
   logic [62:0]              n_ff;
   logic [31:0]              q5_ff;
   logic [62:0]              n5_ff;
   logic [63:0]              qd_ff;
   logic [63:0]              rem_in;
   logic [31:0]              t24_ff;
   logic [31:0]              t24b_ff;
   logic [31:0]              t2_ff;
   logic [39:0]              t3_ff;
   logic [63:0]              quad_ff;
   logic [63:0]              cub_ff;
   logic [63:0]              base_ff;
   logic [31:0]              adj_ff;
   logic [63:0]              lst_in;
   logic [ANGLE_BITS-1:0]    ha_ff;

   // advance unless the last stage is blocked by a full queue
   assign adv       = !(vld_ff[LAST] && q_status.full);
   assign req_stall = !adv;
   assign q_push    = vld_ff[LAST] && !q_status.full;
   assign q_push_data = {ha_ff, side_ff[LAST].dec};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAST-1:0], req_valid};
      end
   end

   // time since J2000, its sign and saturated magnitude
   assign d_in    = {req_payload.unix_seconds[63], req_payload.unix_seconds}
                    - {1'b0, e2h_pkg::J2000_UNIX};
   assign absd_in = d_ff[64] ? (65'd0 - d_ff) : d_ff;
   assign mag_in  = (absd_in > {26'd0, e2h_pkg::POLY_SPAN}) ? e2h_pkg::POLY_SPAN
                                                            : absd_in[38:0];

   assign side_in = '{lin: 64'd0, ra: req_payload.ra_turns,
                      dec: req_payload.declination, neg: d_in[64]};

   // remainder check for the century quotient
   assign rem_in = {1'b0, n5_ff} - qd_ff;

   // local sidereal time minus right ascension
   assign lst_in = base_ff + {adj_ff, 32'd0}
                   + (side_ff[8].neg ? cub_ff : (64'd0 - cub_ff));

   always_ff @(posedge clock) begin
      if (adv) begin
         // carry side data down the pipe, adding the linear term on the way
         side_ff[0] <= side_in;
         for (int k = 1; k < e2h_pkg::FRONT_STAGES; k++) begin
            if (k != LIN_STAGE) begin
               side_ff[k] <= side_ff[k-1];
            end
         end
         side_ff[LIN_STAGE] <= '{lin: p0_ff + {p1_ff[31:0] + p2_ff, 32'd0},
                                 ra:  side_ff[LIN_STAGE-1].ra,
                                 dec: side_ff[LIN_STAGE-1].dec,
                                 neg: side_ff[LIN_STAGE-1].neg};

         // stage 1 and 2: difference and magnitude
         d_ff   <= d_in;
         sw_ff  <= d_ff[63:0];
         mag_ff <= mag_in;

         // stage 3: reciprocal and linear rate partial products
         pl_ff   <= mag_ff[19:0] * e2h_pkg::T_RECIP;
         ph_ff   <= mag_ff[38:20] * e2h_pkg::T_RECIP;
         p0_ff   <= sw_ff[31:0] * e2h_pkg::GMST_RATE[31:0];
         p1_ff   <= sw_ff[31:0] * e2h_pkg::GMST_RATE[47:32];
         p2_ff   <= 32'(sw_ff[63:32] * e2h_pkg::GMST_RATE[31:0]);
         magc_ff <= mag_ff;

         // stage 4: quotient estimate
         q_ff <= 32'(({20'd0, pl_ff} + ({21'd0, ph_ff} << 20)) >> 40);
         n_ff <= {magc_ff, 24'd0};

         // stage 5: back-multiply
         qd_ff <= q_ff * e2h_pkg::SEC_PER_CENTURY;
         q5_ff <= q_ff;
         n5_ff <= n_ff;

         // stage 6: correct quotient by one
         t24_ff <= q5_ff + ((rem_in >= {32'd0, e2h_pkg::SEC_PER_CENTURY}) ? 32'd1 : 32'd0);

         // stage 7: square
         t2_ff   <= 32'(({32'd0, t24_ff} * {32'd0, t24_ff}) >> 32);
         t24b_ff <= t24_ff;

         // stage 8: cube and quadratic term
         t3_ff   <= 40'(({32'd0, t2_ff} * {32'd0, t24b_ff}) >> 24);
         quad_ff <= {32'd0, t2_ff} * {35'd0, e2h_pkg::GMST_QUAD};

         // stage 9: cubic term and partial sums
         cub_ff  <= 64'(({23'd0, t3_ff} * {40'd0, e2h_pkg::GMST_CUBE}) >> 8);
         base_ff <= e2h_pkg::GMST_C0 + side_ff[7].lin + quad_ff;
         adj_ff  <= longitude - side_ff[7].ra;

         // stage 10: hour angle
         ha_ff <= lst_in[63:64-ANGLE_BITS];
      end
   end

endmodule

>>> src/e2h_queue.sv
// ----------------------------------------------------------------------------
// e2h_queue
// Short request queue between the front and back pipelines.
// ----------------------------------------------------------------------------
module e2h_queue #(
   parameter int WIDTH = e2h_pkg::ANGLE_BITS_DEFAULT + 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [WIDTH-1:0]      push_data,
   input  logic                  pop,
   output logic [WIDTH-1:0]      pop_data,
   output e2h_pkg::q_status_type status
);

   localparam int PW = $clog2(e2h_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(e2h_pkg::QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [e2h_pkg::QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [CW-1:0]    cnt_ff;
   logic             do_push;
   logic             do_pop;

   assign status.full  = (cnt_ff == CW'(e2h_pkg::QUEUE_DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = mem_ff[rd_ptr_ff];

   // store incoming request
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + CW'(1);
         end else if (!do_push && do_pop) begin
            cnt_ff <= cnt_ff - CW'(1);
         end
      end
   end

endmodule

>>> src/e2h_vector.sv
// ----------------------------------------------------------------------------
// e2h_vector
// Pipelined CORDIC vectoring: angle and scaled magnitude of (x, y), one
// iteration per stage, with a side word carried alongside.
// ----------------------------------------------------------------------------
module e2h_vector #(
   parameter int ANGLE_BITS        = e2h_pkg::ANGLE_BITS_DEFAULT,
   parameter int CORDIC_ITERATIONS = e2h_pkg::CORDIC_ITERATIONS_DEFAULT,
   parameter int AUX_BITS          = e2h_pkg::VW
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          valid_in,
   input  logic signed [e2h_pkg::VW-1:0] x_in,
   input  logic signed [e2h_pkg::VW-1:0] y_in,
   input  logic [AUX_BITS-1:0]           aux_in,
   output logic                          valid_out,
   output logic signed [e2h_pkg::VW-1:0] mag,
   output logic [ANGLE_BITS-1:0]         angle,
   output logic [AUX_BITS-1:0]           aux_out
);

   localparam int N  = CORDIC_ITERATIONS;
   localparam int VW = e2h_pkg::VW;
   localparam logic [ANGLE_BITS-1:0] AHALF = {1'b1, {(ANGLE_BITS-1){1'b0}}};

   logic [N:0]                vld_ff;
   logic signed [VW-1:0]      vx_ff  [N+1];
   logic signed [VW-1:0]      vy_ff  [N+1];
   logic [ANGLE_BITS-1:0]     vz_ff  [N+1];
   logic [AUX_BITS-1:0]       aux_ff [N+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[N-1:0], valid_in};
      end
   end

   // fold the left half plane onto the right
   always_ff @(posedge clock) begin
      if (adv) begin
         if (x_in < 0) begin
            vx_ff[0] <= -x_in;
            vy_ff[0] <= -y_in;
            vz_ff[0] <= AHALF;
         end else begin
            vx_ff[0] <= x_in;
            vy_ff[0] <= y_in;
            vz_ff[0] <= '0;
         end
         aux_ff[0] <= aux_in;
      end
   end

   // drive y towards zero, one micro-rotation per stage
   for (genvar i = 0; i < N; i++) begin : g_iter
      localparam logic [ANGLE_BITS-1:0] AT =
         ANGLE_BITS'(e2h_pkg::atan_entry(i, ANGLE_BITS));
      always_ff @(posedge clock) begin
         if (adv) begin
            if (vy_ff[i] > 0) begin
               vx_ff[i+1] <= vx_ff[i] + (vy_ff[i] >>> i);
               vy_ff[i+1] <= vy_ff[i] - (vx_ff[i] >>> i);
               vz_ff[i+1] <= vz_ff[i] + AT;
            end else begin
               vx_ff[i+1] <= vx_ff[i] - (vy_ff[i] >>> i);
               vy_ff[i+1] <= vy_ff[i] + (vx_ff[i] >>> i);
               vz_ff[i+1] <= vz_ff[i] - AT;
            end
            aux_ff[i+1] <= aux_ff[i];
         end
      end
   end

   assign valid_out = vld_ff[N];
   assign mag       = vx_ff[N];
   assign angle     = vz_ff[N];
   assign aux_out   = aux_ff[N];

endmodule

>>> src/e2h_back.sv
// ----------------------------------------------------------------------------
// e2h_back
// Takes hour angle and declination from the queue, rotates the three angles,
// forms the horizon vector and resolves azimuth and altitude.
// ----------------------------------------------------------------------------
module e2h_back #(
   parameter int ANGLE_BITS        = e2h_pkg::ANGLE_BITS_DEFAULT,
   parameter int CORDIC_ITERATIONS = e2h_pkg::CORDIC_ITERATIONS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  e2h_pkg::q_status_type     q_status,
   input  logic [ANGLE_BITS+31:0]    q_data,
   output logic                      q_pop,
   input  logic signed [31:0]        latitude,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output e2h_pkg::rsp_payload_type  rsp_payload
);

   localparam int N       = CORDIC_ITERATIONS;
   localparam int VW      = e2h_pkg::VW;
   localparam int ZW      = ANGLE_BITS + 2;
   localparam int LANES   = 3;
   localparam int LANE_HA  = 0;
   localparam int LANE_DEC = 1;
   localparam int LANE_LAT = 2;
   localparam logic [ANGLE_BITS-1:0] AQUART = {2'b01, {(ANGLE_BITS-2){1'b0}}};

   logic                   adv;
   logic [ANGLE_BITS-1:0]  ang_in  [LANES];
   logic [N:0]             rvld_ff;
   logic signed [VW-1:0]   rx_ff   [LANES][N+1];
   logic signed [VW-1:0]   ry_ff   [LANES][N+1];
   logic signed [ZW-1:0]   rz_ff   [LANES][N+1];
   logic                   rflip_ff[LANES][N+1];
   logic signed [VW-1:0]   cos_ff  [LANES];
   logic signed [VW-1:0]   sin_ff  [LANES];
   logic                   cs_vld_ff;

   logic                   m_vld_ff;
   logic signed [VW-1:0]   m_sdcl_ff;
   logic signed [VW-1:0]   m_slch_ff;
   logic signed [VW-1:0]   m_shcd_ff;
   logic signed [VW-1:0]   m_sdsl_ff;
   logic signed [VW-1:0]   m_cdcl_ff;
   logic signed [VW-1:0]   cd_ff;
   logic signed [VW-1:0]   ch_ff;

   logic                   h_vld_ff;
   logic signed [VW-1:0]   xn_ff;
   logic signed [VW-1:0]   ye_ff;
   logic signed [VW-1:0]   zz_ff;

   logic                   v1_vld;
   logic signed [VW-1:0]   v1_mag;
   logic [ANGLE_BITS-1:0]  v1_az;
   logic [VW-1:0]          v1_zz;

   logic                   rr_vld_ff;
   logic signed [VW-1:0]   rr_ff;
   logic signed [VW-1:0]   rr_zz_ff;
   logic [ANGLE_BITS-1:0]  rr_az_ff;

   logic                   v2_vld;
   logic [ANGLE_BITS-1:0]  v2_alt;
   logic [ANGLE_BITS-1:0]  v2_az;

   logic                   rsp_valid_ff;
   e2h_pkg::rsp_payload_type rsp_payload_ff;

   // whole pipe moves unless a finished result is held
   assign adv   = !rsp_valid_ff || !rsp_stall;
   assign q_pop = adv && !q_status.empty;

   // lane angles, rescaled to the internal word
   assign ang_in[LANE_HA]  = q_data[ANGLE_BITS+31:32];
   assign ang_in[LANE_DEC] = ANGLE_BITS'({q_data[31:0], {ANGLE_BITS{1'b0}}} >> 32);
   assign ang_in[LANE_LAT] = ANGLE_BITS'({latitude, {ANGLE_BITS{1'b0}}} >> 32);

   always_ff @(posedge clock) begin
      if (reset) begin
         rvld_ff      <= '0;
         cs_vld_ff    <= 1'b0;
         m_vld_ff     <= 1'b0;
         h_vld_ff     <= 1'b0;
         rr_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rvld_ff      <= {rvld_ff[N-1:0], q_pop};
         cs_vld_ff    <= rvld_ff[N];
         m_vld_ff     <= cs_vld_ff;
         h_vld_ff     <= m_vld_ff;
         rr_vld_ff    <= v1_vld;
         rsp_valid_ff <= v2_vld;
      end
   end

   // rotation lanes: cosine and sine of hour angle, declination, latitude
   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [ANGLE_BITS-1:0] sum_in;
      logic                  flip_in;
      logic [ANGLE_BITS-1:0] w_in;

      assign sum_in  = ang_in[l] + AQUART;
      assign flip_in = sum_in[ANGLE_BITS-1];
      assign w_in    = flip_in ? (ang_in[l] ^ {1'b1, {(ANGLE_BITS-1){1'b0}}}) : ang_in[l];

      // bring the angle into the right half plane
      always_ff @(posedge clock) begin
         if (adv) begin
            rx_ff[l][0]    <= e2h_pkg::INV_GAIN_Q30;
            ry_ff[l][0]    <= '0;
            rz_ff[l][0]    <= {{2{w_in[ANGLE_BITS-1]}}, w_in};
            rflip_ff[l][0] <= flip_in;
         end
      end

      for (genvar i = 0; i < N; i++) begin : g_iter
         localparam logic signed [ZW-1:0] AT =
            ZW'(e2h_pkg::atan_entry(i, ANGLE_BITS));
         always_ff @(posedge clock) begin
            if (adv) begin
               if (!rz_ff[l][i][ZW-1]) begin
                  rx_ff[l][i+1] <= rx_ff[l][i] - (ry_ff[l][i] >>> i);
                  ry_ff[l][i+1] <= ry_ff[l][i] + (rx_ff[l][i] >>> i);
                  rz_ff[l][i+1] <= rz_ff[l][i] - AT;
               end else begin
                  rx_ff[l][i+1] <= rx_ff[l][i] + (ry_ff[l][i] >>> i);
                  ry_ff[l][i+1] <= ry_ff[l][i] - (rx_ff[l][i] >>> i);
                  rz_ff[l][i+1] <= rz_ff[l][i] + AT;
               end
               rflip_ff[l][i+1] <= rflip_ff[l][i];
            end
         end
      end

      // undo the half turn fold
      always_ff @(posedge clock) begin
         if (adv) begin
            cos_ff[l] <= rflip_ff[l][N] ? -rx_ff[l][N] : rx_ff[l][N];
            sin_ff[l] <= rflip_ff[l][N] ? -ry_ff[l][N] : ry_ff[l][N];
         end
      end
   end

   // horizon vector, first products then the second products and sums
   always_ff @(posedge clock) begin
      if (adv) begin
         m_sdcl_ff <= e2h_pkg::mulq(sin_ff[LANE_DEC], cos_ff[LANE_LAT]);
         m_slch_ff <= e2h_pkg::mulq(sin_ff[LANE_LAT], cos_ff[LANE_HA]);
         m_shcd_ff <= e2h_pkg::mulq(sin_ff[LANE_HA], cos_ff[LANE_DEC]);
         m_sdsl_ff <= e2h_pkg::mulq(sin_ff[LANE_DEC], sin_ff[LANE_LAT]);
         m_cdcl_ff <= e2h_pkg::mulq(cos_ff[LANE_DEC], cos_ff[LANE_LAT]);
         cd_ff     <= cos_ff[LANE_DEC];
         ch_ff     <= cos_ff[LANE_HA];

         xn_ff <= m_sdcl_ff - e2h_pkg::mulq(m_slch_ff, cd_ff);
         ye_ff <= -m_shcd_ff;
         zz_ff <= m_sdsl_ff + e2h_pkg::mulq(m_cdcl_ff, ch_ff);
      end
   end

   // azimuth from north and east parts
   e2h_vector #(
      .ANGLE_BITS       (ANGLE_BITS),
      .CORDIC_ITERATIONS(CORDIC_ITERATIONS),
      .AUX_BITS         (VW)
   ) u_vec_az (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .valid_in (h_vld_ff),
      .x_in     (xn_ff),
      .y_in     (ye_ff),
      .aux_in   (zz_ff),
      .valid_out(v1_vld),
      .mag      (v1_mag),
      .angle    (v1_az),
      .aux_out  (v1_zz)
   );

   // remove CORDIC gain from the horizontal magnitude
   always_ff @(posedge clock) begin
      if (adv) begin
         rr_ff    <= e2h_pkg::mulq(v1_mag, e2h_pkg::INV_GAIN_Q30);
         rr_zz_ff <= v1_zz;
         rr_az_ff <= v1_az;
      end
   end

   // altitude from horizontal magnitude and vertical part
   e2h_vector #(
      .ANGLE_BITS       (ANGLE_BITS),
      .CORDIC_ITERATIONS(CORDIC_ITERATIONS),
      .AUX_BITS         (ANGLE_BITS)
   ) u_vec_alt (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .valid_in (rr_vld_ff),
      .x_in     (rr_ff),
      .y_in     (rr_zz_ff),
      .aux_in   (rr_az_ff),
      .valid_out(v2_vld),
      .mag      (),
      .angle    (v2_alt),
      .aux_out  (v2_az)
   );

   // rescale to 32 bit turn words and hold for the consumer
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_payload_ff.altitude <= 32'({v2_alt, 32'd0} >> ANGLE_BITS);
         rsp_payload_ff.azimuth  <= 32'({v2_az, 32'd0} >> ANGLE_BITS);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

>>> src/equatorial_to_horizontal.sv
// ----------------------------------------------------------------------------
// equatorial_to_horizontal
// Converts right ascension and declination at a Unix time into altitude and
// azimuth for the configured observer position.
// ----------------------------------------------------------------------------
// Takes one request per clock while req_stall is low and returns one response
// per request, in order. Ten front stages work out the hour angle from the
// sidereal time polynomial, the request then passes through the queue, then
// three parallel CORDIC rotation lanes, two product stages and two chained
// CORDIC vectoring pipelines, one stage per iteration. Throughput is one
// request per cycle when no stall holds the pipes, set by the fully pipelined
// CORDIC lanes. A four entry queue between the front and back lets the front
// keep taking requests while a response is held by rsp_stall, until the queue
// fills. The user must write longitude and latitude through the csr_ port only
// while no request is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module equatorial_to_horizontal #(
   parameter int ANGLE_BITS        = e2h_pkg::ANGLE_BITS_DEFAULT,
   parameter int CORDIC_ITERATIONS = e2h_pkg::CORDIC_ITERATIONS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  e2h_pkg::req_payload_type               req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output e2h_pkg::rsp_payload_type               rsp_payload,
   input  logic                                   csr_write_enable,
   input  logic [e2h_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [31:0]                            csr_write_data
);

   logic signed [31:0]        longitude_ff;
   logic signed [31:0]        latitude_ff;
   e2h_pkg::q_status_type     q_status;
   logic                      q_push;
   logic                      q_pop;
   logic [ANGLE_BITS+31:0]    q_push_data;
   logic [ANGLE_BITS+31:0]    q_pop_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         longitude_ff <= '0;
         latitude_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (e2h_pkg::csr_index_type'(csr_index))
            e2h_pkg::CSR_LONGITUDE: longitude_ff <= csr_write_data;
            e2h_pkg::CSR_LATITUDE:  latitude_ff  <= csr_write_data;
         endcase
      end
   end

   e2h_front #(
      .ANGLE_BITS(ANGLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .longitude  (longitude_ff),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_push_data(q_push_data)
   );

   e2h_queue #(
      .WIDTH(ANGLE_BITS + 32)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_push_data),
      .pop      (q_pop),
      .pop_data (q_pop_data),
      .status   (q_status)
   );

   e2h_back #(
      .ANGLE_BITS       (ANGLE_BITS),
      .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_data     (q_pop_data),
      .q_pop      (q_pop),
      .latitude   (latitude_ff),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

`ifndef SYNTH
   // a held response freezes the back pipe, so nothing leaves the queue
   a_no_pop_when_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !q_pop)
      else $error("queue popped while response held");

   // queue cannot be full and empty at once
   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue status inconsistent");

   // a push with no pop leaves the queue non-empty
   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (q_push && !q_pop) |=> !q_status.empty)
      else $error("queue lost a pushed request");

   // with a full queue and a stalled request side, the front does not push
   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (q_status.full && !q_push && req_stall) |-> !q_push)
      else $error("front pushed into a full queue");
`endif

endmodule

>>> tb/tb_equatorial_to_horizontal.sv
// ----------------------------------------------------------------------------
// tb_equatorial_to_horizontal
// Self-checking bench for the equatorial to horizontal converter. Requests
// are sent through the req_ channel and each response is compared with an
// altitude and azimuth worked out by a bit-exact sidereal time and CORDIC
// predictor, over several observer settings, random gaps and a long stall.
// ----------------------------------------------------------------------------
module tb_equatorial_to_horizontal;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] EPOCH_J2000   = 64'd946728000;
   localparam logic [63:0] CENTURY_SECS  = 64'd3155760000;
   localparam logic [63:0] CLAMP_SECS    = 64'd1 << 38;
   localparam longint      RECIP_GAIN    = 652032874;
   localparam int          SETTLE_CYCLES = 150;
   localparam int          WATCHDOG_MAX  = 5000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   e2h_pkg::req_payload_type req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   e2h_pkg::rsp_payload_type rsp_payload;
   logic                     csr_write_enable = 1'b0;
   e2h_pkg::csr_index_type   csr_index = e2h_pkg::CSR_LONGITUDE;
   logic [31:0]              csr_write_data = '0;

   // observer position as the block holds it
   logic [31:0]     obs_longitude = '0;
   logic [31:0]     obs_latitude = '0;

   e2h_pkg::rsp_payload_type pending_horizon[$];
   longint          atan_turns[32];
   logic [63:0]     sid_offset, sid_rate, sid_quad, sid_cube;
   bit              quiet_mode = 1'b0;
   int              hold_cycles = 0;
   int              idle_count = 0;
   bit              failed = 1'b0;

   equatorial_to_horizontal u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // floor(num * 2^64 / den) by long division
   function automatic logic [63:0] ratio_q64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] r;
      logic [63:0] q;
      r = num;
      q = '0;
      for (int b = 0; b < 64; b++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   // arctangent of 2^-i in turns * 2^32, from the series for atan
   function automatic longint atan_step(input int i);
      logic [63:0]  rad;
      logic [63:0]  term;
      logic [127:0] prod;
      logic [63:0]  t64;
      int           e;
      if (i == 0) return longint'(64'd1 << 29);
      rad = '0;
      for (int k = 0; k < 40; k++) begin
         e = i * (2 * k + 1);
         if (e > 62) break;
         term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
         if (k % 2 == 1) rad = rad - term;
         else rad = rad + term;
      end
      prod = {64'd0, rad} * {64'd0, 64'h28BE60DB9391054A};
      t64  = prod[125:62];
      return longint'((t64 + (64'd1 << 31)) >> 32);
   endfunction

   function automatic longint qmul(input longint a, input longint b);
      return (a * b) >>> 30;
   endfunction

   // local sidereal time as a 64 bit turn word
   function automatic logic [63:0] local_sidereal(input logic [63:0] u);
      logic [63:0] sw, mag, t24, t2, t3, quad, cub, gmst;
      bit          neg;
      sw = u - EPOCH_J2000;
      if (u[63]) begin
         neg = 1'b1;
         mag = (~u + 64'd1) + EPOCH_J2000;
      end else if (u >= EPOCH_J2000) begin
         neg = 1'b0;
         mag = u - EPOCH_J2000;
      end else begin
         neg = 1'b1;
         mag = EPOCH_J2000 - u;
      end
      if (mag > CLAMP_SECS) mag = CLAMP_SECS;
      t24  = (mag << 24) / CENTURY_SECS;
      t2   = (t24 * t24) >> 32;
      t3   = (t2 * t24) >> 24;
      quad = t2 * sid_quad;
      cub  = (t3 * sid_cube) >> 8;
      gmst = sid_offset + sw * sid_rate + quad;
      if (neg) gmst = gmst + cub;
      else gmst = gmst - cub;
      return gmst + {obs_longitude, 32'd0};
   endfunction

   task automatic cordic_sincos(input logic [31:0] ang, output longint c, output longint s);
      logic [31:0] w;
      logic [31:0] probe;
      bit          flip;
      longint      x, y, z, nx;
      w = ang;
      probe = w + 32'h4000_0000;
      flip = probe[31];
      if (flip) w = w + 32'h8000_0000;
      z = longint'($signed(w));
      x = RECIP_GAIN;
      y = 0;
      for (int i = 0; i < 32; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - atan_turns[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + atan_turns[i];
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = x;
      s = y;
   endtask

   task automatic cordic_atan2(input longint xi, input longint yi, output longint mag,
                               output logic [31:0] ang);
      logic [63:0] z;
      longint      x, y, nx;
      x = xi;
      y = yi;
      z = '0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 64'h8000_0000;
      end
      for (int i = 0; i < 32; i++) begin
         if (y > 0) begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + 64'(atan_turns[i]);
         end else begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - 64'(atan_turns[i]);
         end
         x = nx;
      end
      mag = x;
      ang = z[31:0];
   endtask

   task automatic predict_horizon(input e2h_pkg::req_payload_type r,
                                  output e2h_pkg::rsp_payload_type p);
      logic [63:0] lst;
      logic [31:0] hour_angle, az, alt;
      longint      ch, sh, cd, sd, cl, sl, xn, ye, zz, rad, rr, unused;
      lst = local_sidereal(r.unix_seconds);
      hour_angle = lst[63:32] - r.ra_turns;
      cordic_sincos(hour_angle, ch, sh);
      cordic_sincos(r.declination, cd, sd);
      cordic_sincos(obs_latitude, cl, sl);
      xn = qmul(sd, cl) - qmul(qmul(sl, ch), cd);
      ye = -qmul(sh, cd);
      zz = qmul(sd, sl) + qmul(qmul(cd, cl), ch);
      cordic_atan2(xn, ye, rad, az);
      rr = qmul(rad, RECIP_GAIN);
      cordic_atan2(rr, zz, unused, alt);
      p.altitude = alt;
      p.azimuth  = az;
   endtask

   // offer one request, with an occasional gap first, and hold it until taken
   task automatic send_request(input logic [63:0] secs, input logic [31:0] ra,
                               input logic [31:0] dec);
      e2h_pkg::req_payload_type r;
      e2h_pkg::rsp_payload_type p;
      r.unix_seconds = secs;
      r.ra_turns     = ra;
      r.declination  = dec;
      if (!quiet_mode && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      predict_horizon(r, p);
      pending_horizon.push_back(p);
   endtask

   task automatic drain_requests;
      req_valid <= 1'b0;
      wait (pending_horizon.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write one register once the pipeline is empty
   task automatic write_csr(input e2h_pkg::csr_index_type idx, input logic [31:0] value);
      drain_requests();
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == e2h_pkg::CSR_LONGITUDE) obs_longitude = value;
      else obs_latitude = value;
   endtask

   function automatic logic [63:0] rand_time();
      case ($urandom_range(3))
         0: return {$urandom, $urandom};
         1: return EPOCH_J2000 + 64'($signed($urandom));
         2: return 64'($signed({$urandom_range(255), $urandom})) * 64'd8;
         default: return EPOCH_J2000 + {1'($urandom_range(1)), 6'd0, $urandom, 25'd0};
      endcase
   endfunction

   function automatic logic [31:0] rand_dec();
      if ($urandom_range(9) == 0) return $urandom;
      return 32'($urandom_range(32'h8000_0000)) - 32'h4000_0000;
   endfunction

   task automatic test_time_extremes;
      logic [63:0] times[8];
      times = '{64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0, EPOCH_J2000,
                EPOCH_J2000 + CLAMP_SECS, EPOCH_J2000 - CLAMP_SECS - 64'd1,
                64'hFFFF_FFFF_FFFF_FFFF, 64'd1700000000};
      foreach (times[i]) send_request(times[i], i[0] ? 32'hFFFF_FFFF : 32'd0,
                                      i[1] ? 32'h4000_0000 : 32'hC000_0000);
   endtask

   task automatic test_angle_extremes;
      logic [31:0] decs[6];
      decs = '{32'h4000_0000, 32'hC000_0000, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
      foreach (decs[i]) send_request(64'd1234567890, $urandom, decs[i]);
   endtask

   // hour angle of half a turn, zenith and nadir
   task automatic test_special_geometry;
      logic [63:0] lst;
      logic [63:0] t;
      t = 64'd1600000000;
      write_csr(e2h_pkg::CSR_LATITUDE, 32'h1555_5555);
      lst = local_sidereal(t);
      send_request(t, lst[63:32] + 32'h8000_0000, 32'h0800_0000);
      send_request(t, lst[63:32], obs_latitude);
      send_request(t, lst[63:32] + 32'h8000_0000, -obs_latitude);
      send_request(t, lst[63:32], 32'h4000_0000);
   endtask

   task automatic test_config_sweep;
      logic [31:0] lons[4];
      logic [31:0] lats[4];
      lons = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, $urandom};
      lats = '{32'h4000_0000, 32'hC000_0000, 32'd0, 32'h6000_0000};
      for (int k = 0; k < 4; k++) begin
         write_csr(e2h_pkg::CSR_LONGITUDE, lons[k]);
         write_csr(e2h_pkg::CSR_LATITUDE, lats[k]);
         repeat (60) send_request(rand_time(), $urandom, rand_dec());
      end
   endtask

   // hold off the response side while requests keep coming
   task automatic test_backpressure;
      write_csr(e2h_pkg::CSR_LATITUDE, 32'h0E38_E38E);
      hold_cycles = 400;
      repeat (150) send_request(rand_time(), $urandom, rand_dec());
   endtask

   task automatic test_random_stream;
      write_csr(e2h_pkg::CSR_LONGITUDE, $urandom);
      write_csr(e2h_pkg::CSR_LATITUDE, rand_dec());
      repeat (200) send_request(rand_time(), $urandom, rand_dec());
      quiet_mode = 1'b1;
      repeat (150) send_request(rand_time(), $urandom, rand_dec());
      quiet_mode = 1'b0;
      write_csr(e2h_pkg::CSR_LONGITUDE, $urandom);
      write_csr(e2h_pkg::CSR_LATITUDE, $urandom);
      repeat (200) send_request(rand_time(), $urandom, rand_dec());
   endtask

   // response side stall: random, or a long hold when asked
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles = hold_cycles - 1;
      end else if (quiet_mode) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 9);
      end
   end

   // compare each response with the oldest prediction
   always @(posedge clock) begin
      e2h_pkg::rsp_payload_type exp_p;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_horizon.size() == 0) begin
            $error("response with nothing expected: alt %h az %h",
                   rsp_payload.altitude, rsp_payload.azimuth);
            failed = 1'b1;
         end else begin
            exp_p = pending_horizon.pop_front();
            if (rsp_payload.altitude !== exp_p.altitude) begin
               $error("altitude expected %h actual %h", exp_p.altitude, rsp_payload.altitude);
               failed = 1'b1;
            end
            if (rsp_payload.azimuth !== exp_p.azimuth) begin
               $error("azimuth expected %h actual %h", exp_p.azimuth, rsp_payload.azimuth);
               failed = 1'b1;
            end
         end
      end
   end

   // watchdog on cycles without any accepted request or response
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_count = 0;
      end else begin
         idle_count = idle_count + 1;
         if (idle_count >= WATCHDOG_MAX) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      sid_offset = ratio_q64(64'd28046061837, 64'd36000000000);
      sid_rate   = ratio_q64(64'd36098564736629, 64'd3110400000000000000);
      sid_quad   = ratio_q64(64'd387933, 64'd360000000000) >> 16;
      sid_cube   = ratio_q64(64'd1, 64'd13935600000) >> 8;
      for (int i = 0; i < 32; i++) atan_turns[i] = atan_step(i);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_time_extremes();
      test_angle_extremes();
      test_special_geometry();
      test_config_sweep();
      test_backpressure();
      test_random_stream();
      drain_requests();
      if (!failed && pending_horizon.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
